/* hdl/bfha_pkg.sv */
package bfha_pkg;

    localparam int DEF_HEAP_UNITS = 4096;
    localparam int DEF_UNIT_BYTES = 16;
    localparam int DATA_W         = 32;
    localparam int BYTES_W        = 16;
    localparam int UNITS_CFG_W    = 13;
    localparam int RESET_UNITS    = 4096;
    localparam int MIN_UNITS      = 2;

    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_UNITS = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO     = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

endpackage

/* hdl/bfha_div.sv */
module bfha_div #(
    parameter int DIVISOR = bfha_pkg::DEF_UNIT_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bfha_pkg::DATA_W-1:0] i_dividend,
    output logic                        o_done,
    output logic [bfha_pkg::DATA_W-1:0] o_quot,
    output logic [$clog2(DIVISOR):0]    o_rem
);
    localparam int RW = $clog2(DIVISOR) + 1;
    localparam int DW = bfha_pkg::DATA_W;
    localparam int HW = DW / 2;
    localparam int MW = DW + 1;
    localparam int XW = HW + MW;
    localparam int K  = DW + $clog2(DIVISOR);
    localparam int PW = K + DW;
    // rounded-up reciprocal, exact for every dividend of DW bits
    localparam logic [63:0] RECIP64 = ((64'd1 << K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP = RECIP64[MW-1:0];

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_LO   = 3'd1;
    localparam logic [2:0] C_HI   = 3'd2;
    localparam logic [2:0] C_QUOT = 3'd3;
    localparam logic [2:0] C_REM  = 3'd4;

    logic [2:0]    r_step, n_step;
    logic          r_done, n_done;
    logic [DW-1:0] r_x, n_x;
    logic [PW-1:0] r_acc, n_acc;
    logic [DW-1:0] r_q, n_q;
    logic [RW-1:0] r_rem, n_rem;
    logic [XW-1:0] w_part;

    // one half of the dividend a cycle through the shared multiplier
    assign w_part = XW'((r_step == C_LO) ? r_x[HW-1:0] : r_x[DW-1:HW]) * XW'(RECIP);

    always_comb begin
        n_step = r_step;
        n_done = 1'b0;
        n_x    = r_x;
        n_acc  = r_acc;
        n_q    = r_q;
        n_rem  = r_rem;
        if (i_start) begin
            n_step = C_LO;
            n_x    = i_dividend;
        end else begin
            unique case (r_step)
                C_LO: begin
                    n_acc  = PW'(w_part);
                    n_step = C_HI;
                end
                C_HI: begin
                    n_acc  = r_acc + (PW'(w_part) << HW);
                    n_step = C_QUOT;
                end
                C_QUOT: begin
                    n_q    = r_acc[PW-1:K];
                    n_step = C_REM;
                end
                C_REM: begin
                    n_rem  = RW'(r_x - r_q * DW'(DIVISOR));
                    n_done = 1'b1;
                    n_step = C_IDLE;
                end
                default: begin
                    n_step = C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= C_IDLE;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= n_done;
        end
        r_x   <= n_x;
        r_acc <= n_acc;
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

/* hdl/bfha_store.sv */
module bfha_store #(
    parameter int DEPTH = bfha_pkg::DEF_HEAP_UNITS,
    parameter int AW    = $clog2(DEPTH),
    parameter int EW    = AW + 2
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [EW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [EW-1:0] o_rdata
);
    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/best_fit_heap_allocator.sv */
// Allocate: unit division, a walk of the block headers (read, evaluate each), then commit,
// split and result as needed; free: unit division, header check, next-block merge, write-back
// and a walk of the headers ahead of the freed block. The header store's single read port and
// the shared chain adder set the walk pace. One word at a time; a new start is taken in idle.
// Reset (synchronous, active low) and every heap_units write start a clearing pass over
// every entry of the header store; busy stays high until it ends. The result strobe
// is high for exactly one cycle and the receiver cannot stall it.
module best_fit_heap_allocator #(
    parameter int HEAP_UNITS = bfha_pkg::DEF_HEAP_UNITS,
    parameter int UNIT_BYTES = bfha_pkg::DEF_UNIT_BYTES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_operation,
    input  logic [bfha_pkg::BYTES_W-1:0] i_request_bytes,
    input  logic [bfha_pkg::DATA_W-1:0]  i_free_addr,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [bfha_pkg::DATA_W-1:0]  i_cfg_data,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [bfha_pkg::DATA_W-1:0]  o_block_addr
);
    localparam int AW = $clog2(HEAP_UNITS);   // header store index
    localparam int UW = AW + 1;               // cell count / chain position
    localparam int EW = AW + 2;               // mark, free flag, size
    localparam int NW = bfha_pkg::BYTES_W + 1;
    localparam int DW = bfha_pkg::DATA_W;
    localparam int RW = $clog2(UNIT_BYTES) + 1;
    localparam int UNITS_W = bfha_pkg::UNITS_CFG_W;
    localparam int RST_UNITS = (bfha_pkg::RESET_UNITS > HEAP_UNITS) ? HEAP_UNITS
                                                                     : bfha_pkg::RESET_UNITS;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLEAR   = 4'd1;
    localparam logic [3:0] S_DIV     = 4'd2;
    localparam logic [3:0] S_AREQ    = 4'd3;
    localparam logic [3:0] S_AEVAL   = 4'd4;
    localparam logic [3:0] S_ACOMMIT = 4'd5;
    localparam logic [3:0] S_ASPLIT  = 4'd6;
    localparam logic [3:0] S_FREQ    = 4'd7;
    localparam logic [3:0] S_FCHK    = 4'd8;
    localparam logic [3:0] S_FNREQ   = 4'd9;
    localparam logic [3:0] S_FNX     = 4'd10;
    localparam logic [3:0] S_FWU     = 4'd11;
    localparam logic [3:0] S_PREQ    = 4'd12;
    localparam logic [3:0] S_PEVAL   = 4'd13;
    localparam logic [3:0] S_PCLR    = 4'd14;
    localparam logic [3:0] S_DONE    = 4'd15;

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [UW-1:0] r_units, n_units;
    logic [DW-1:0] r_base, n_base;
    logic          r_op, n_op;
    logic [bfha_pkg::BYTES_W-1:0] r_bytes, n_bytes;
    logic [NW-1:0] r_need, n_need;
    logic [UW-1:0] r_u, n_u;
    logic [UW-1:0] r_best, n_best;
    logic [AW-1:0] r_bsize, n_bsize;
    logic          r_found, n_found;
    logic [AW-1:0] r_usize, n_usize;
    logic [UW-1:0] r_nxt, n_nxt;
    logic [UW-1:0] r_p, n_p;
    logic [1:0]    r_status, n_status;
    logic [DW-1:0] r_addr, n_addr;

    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic          div_done;
    logic [DW-1:0] div_quot;
    logic [RW-1:0] div_rem;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    logic          rd_mark, rd_free;
    logic [AW-1:0] rd_size;
    logic [UW-1:0] w_walk;
    logic [UW-1:0] w_next;
    logic          w_take;
    logic          w_split;
    logic [DW-1:0] w_fu;
    logic [UNITS_W-1:0] w_cfg_units;

    bfha_div #(
        .DIVISOR (UNIT_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    bfha_store #(
        .DEPTH (HEAP_UNITS),
        .AW    (AW),
        .EW    (EW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_mark = mem_rdata[AW+1];
    assign rd_free = mem_rdata[AW];
    assign rd_size = mem_rdata[AW-1:0];

    // shared chain adder: next header follows the current one's payload
    assign w_walk = (r_state == S_PEVAL) ? r_p : r_u;
    assign w_next = w_walk + UW'(1) + UW'(rd_size);

    // a strictly larger free block beats the best so far only when smaller; the first one found is taken
    assign w_take  = rd_free && (32'(rd_size) > 32'(r_need)) &&
                     (!r_found || (r_bsize > rd_size));
    assign w_split = 32'(r_bsize) != 32'(r_need);
    // payload cell index of a free request, minus one gives its header
    assign w_fu    = div_quot - 32'd1;

    assign w_cfg_units = i_cfg_data[UNITS_W-1:0];

    // hold the read address on the header the current step wants next
    always_comb begin
        unique case (r_state)
            S_PREQ:  mem_raddr = r_p[AW-1:0];
            S_FNREQ: mem_raddr = r_nxt[AW-1:0];
            default: mem_raddr = r_u[AW-1:0];
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_units  = r_units;
        n_base   = r_base;
        n_op     = r_op;
        n_bytes  = r_bytes;
        n_need   = r_need;
        n_u      = r_u;
        n_best   = r_best;
        n_bsize  = r_bsize;
        n_found  = r_found;
        n_usize  = r_usize;
        n_nxt    = r_nxt;
        n_p      = r_p;
        n_status = r_status;
        n_addr   = r_addr;

        div_start    = 1'b0;
        div_dividend = i_free_addr - r_base;
        mem_we       = 1'b0;
        mem_waddr    = r_u[AW-1:0];
        mem_wdata    = '0;

        unique case (r_state)
            S_CLEAR: begin
                // wipe every header; cell zero becomes the single free block
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                if (r_ptr == '0) begin
                    mem_wdata = {1'b1, 1'b1, AW'(r_units - UW'(1))};
                end
                if (r_ptr == AW'(HEAP_UNITS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    div_start = 1'b1;
                    if (i_operation == bfha_pkg::OP_ALLOC) begin
                        div_dividend = DW'(i_request_bytes);
                    end
                    n_op     = i_operation;
                    n_bytes  = i_request_bytes;
                    n_status = bfha_pkg::ST_OK;
                    n_addr   = '0;
                    n_found  = 1'b0;
                    n_u      = '0;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (r_op == bfha_pkg::OP_ALLOC) begin
                        if (r_bytes == '0) begin
                            n_status = bfha_pkg::ST_ZERO;
                            n_state  = S_DONE;
                        end else begin
                            n_need  = NW'(div_quot) + NW'(1);
                            n_state = S_AREQ;
                        end
                    end else if ((div_rem != '0) || (div_quot == '0) ||
                                 (w_fu >= 32'(r_units))) begin
                        n_status = bfha_pkg::ST_BAD_FREE;
                        n_state  = S_DONE;
                    end else begin
                        n_u     = UW'(w_fu);
                        n_state = S_FREQ;
                    end
                end
            end
            S_AREQ: begin
                n_state = S_AEVAL;
            end
            S_AEVAL: begin
                if (rd_free && (32'(rd_size) == 32'(r_need))) begin
                    // exact fit: stop the walk here
                    n_best  = r_u;
                    n_bsize = rd_size;
                    n_found = 1'b1;
                    n_state = S_ACOMMIT;
                end else begin
                    if (w_take) begin
                        n_best  = r_u;
                        n_bsize = rd_size;
                        n_found = 1'b1;
                    end
                    if (w_next >= r_units) begin
                        if (r_found || w_take) begin
                            n_state = S_ACOMMIT;
                        end else begin
                            n_status = bfha_pkg::ST_NO_SPACE;
                            n_state  = S_DONE;
                        end
                    end else begin
                        n_u     = w_next;
                        n_state = S_AREQ;
                    end
                end
            end
            S_ACOMMIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_best[AW-1:0];
                mem_wdata = {1'b1, 1'b0, w_split ? AW'(r_need) : r_bsize};
                n_addr    = r_base + DW'((32'(r_best) + 32'd1) * 32'(UNIT_BYTES));
                n_state   = w_split ? S_ASPLIT : S_DONE;
            end
            S_ASPLIT: begin
                // remainder becomes a free block right after the taken one
                mem_we    = 1'b1;
                mem_waddr = AW'(r_best + UW'(1) + UW'(r_need));
                mem_wdata = {1'b1, 1'b1, AW'(r_bsize - AW'(r_need) - AW'(1))};
                n_state   = S_DONE;
            end
            S_FREQ: begin
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (!rd_mark || rd_free) begin
                    n_status = bfha_pkg::ST_BAD_FREE;
                    n_state  = S_DONE;
                end else begin
                    n_usize = rd_size;
                    n_nxt   = w_next;
                    n_state = (w_next < r_units) ? S_FNREQ : S_FWU;
                end
            end
            S_FNREQ: begin
                n_state = S_FNX;
            end
            S_FNX: begin
                if (rd_free) begin
                    // absorb the next block and drop its header
                    mem_we    = 1'b1;
                    mem_waddr = r_nxt[AW-1:0];
                    n_usize   = r_usize + rd_size + AW'(1);
                end
                n_state = S_FWU;
            end
            S_FWU: begin
                mem_we    = 1'b1;
                mem_waddr = r_u[AW-1:0];
                mem_wdata = {1'b1, 1'b1, r_usize};
                if (r_u == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_p     = '0;
                    n_state = S_PREQ;
                end
            end
            S_PREQ: begin
                n_state = S_PEVAL;
            end
            S_PEVAL: begin
                if (w_next == r_u) begin
                    if (rd_free) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_p[AW-1:0];
                        mem_wdata = {1'b1, 1'b1, rd_size + r_usize + AW'(1)};
                        n_state   = S_PCLR;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (w_next >= r_units) begin
                    n_state = S_DONE;
                end else begin
                    n_p     = w_next;
                    n_state = S_PREQ;
                end
            end
            S_PCLR: begin
                // the freed header is now inside the previous block
                mem_we    = 1'b1;
                mem_waddr = r_u[AW-1:0];
                n_state   = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bfha_pkg::REG_HEAP_BASE: begin
                    n_base = i_cfg_data;
                end
                bfha_pkg::REG_HEAP_UNITS: begin
                    // clamp into the supported range and rebuild the heap
                    if (32'(w_cfg_units) < 32'(bfha_pkg::MIN_UNITS)) begin
                        n_units = UW'(bfha_pkg::MIN_UNITS);
                    end else if (32'(w_cfg_units) > 32'(HEAP_UNITS)) begin
                        n_units = UW'(HEAP_UNITS);
                    end else begin
                        n_units = UW'(w_cfg_units);
                    end
                    n_ptr   = '0;
                    n_state = S_CLEAR;
                end
                default: begin
                    n_base = r_base;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            r_units <= UW'(RST_UNITS);
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_units <= n_units;
            r_base  <= n_base;
        end
        r_op     <= n_op;
        r_bytes  <= n_bytes;
        r_need   <= n_need;
        r_u      <= n_u;
        r_best   <= n_best;
        r_bsize  <= n_bsize;
        r_found  <= n_found;
        r_usize  <= n_usize;
        r_nxt    <= n_nxt;
        r_p      <= n_p;
        r_status <= n_status;
        r_addr   <= n_addr;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = (r_state == S_DONE);
    assign o_status     = r_status;
    assign o_block_addr = r_addr;
endmodule
